>>> design/rwsp_pkg.sv
package rwsp_pkg;

  localparam logic [31:0] ID_RIFF  = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE  = 32'h4556_4157;
  localparam logic [31:0] ID_FMT   = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA  = 32'h6174_6164;
  localparam int unsigned MS_PER_S = 1000;

  localparam int unsigned DVD_W  = 42;
  localparam int unsigned DCNT_W = $clog2(DVD_W);

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_SUM  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  typedef enum logic [2:0] {
    PH_TOP_HDR,
    PH_TOP_SKIP,
    PH_FORM,
    PH_SUB_HDR,
    PH_SUB_SKIP,
    PH_FMT_BODY,
    PH_DATA_BODY,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_EMIT,
    C_MUL,
    C_DIV,
    C_SUM
  } ctrl_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] format_tag;
    logic [15:0] channels;
    logic [31:0] sample_freq;
    logic [31:0] avg_bytes_per_sec;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] wave_bytes;
    logic [31:0] play_time_ms;
  } out_t;

endpackage

>>> design/riff_wave_stream_parser_core.sv
// Channel   Direction  Handshake                     Payload
// request   in         byte_valid / byte_stall       byte_req (in_byte, end_of_stream)
// result    out        result_valid / result_stall   result   (kind, data, fmt summary)
//
// Each request byte is accepted and parsed, then handled in the emit sequencer;
// a data byte followed by an error or a summary stays in emit for the second result.
// A summary adds a 32x10 multiply, 42 divider steps, summary load, back to emit.
// A result waits in the output register; the sequencer holds while it is full and stalled.
// Reset (rst, synchronous) clears the parser, the sequencer and the output valid.
// end_of_stream clears the parser once that byte's results are in the output register.
module riff_wave_stream_parser_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  output logic           byte_stall,
  input  rwsp_pkg::in_t  byte_req,
  output logic           result_valid,
  input  logic           result_stall,
  output rwsp_pkg::out_t result
);
  import rwsp_pkg::*;

  phase_t       phase, phase_next;
  logic [63:0]  header_shift, header_shift_next;
  logic [3:0]   header_count, header_count_next;
  logic [31:0]  body_left, body_left_next;
  logic [31:0]  riff_size, riff_size_next;
  logic [32:0]  riff_consumed, riff_consumed_next;
  logic         fmt_found, fmt_found_next;
  logic [127:0] fmt_shift, fmt_shift_next;
  logic [4:0]   fmt_index, fmt_index_next;
  logic [31:0]  data_total, data_total_next;

  ctrl_t        ctrl, ctrl_next;
  logic         has_data, has_sum, has_err, pend_reset;
  logic         step_data, step_sum, step_err;
  logic [7:0]   data_hold;

  logic [DVD_W-1:0]  dvd, quo;
  logic [32:0]       rem, rem_sh;
  logic [DCNT_W-1:0] div_count;
  logic              div_ge;

  logic acc, out_free, load_data, load_sum, load_err, clr;
  logic sd;
  logic [31:0] id_w, size_w, rate;
  out_t result_next;

  assign acc        = byte_valid && !byte_stall;
  assign byte_stall = (ctrl != C_IDLE);
  assign out_free   = !result_valid || !result_stall;
  assign rate       = fmt_shift[95:64];

  always_comb begin
    phase_next         = phase;
    header_shift_next  = header_shift;
    header_count_next  = header_count;
    body_left_next     = body_left;
    riff_size_next     = riff_size;
    riff_consumed_next = riff_consumed;
    fmt_found_next     = fmt_found;
    fmt_shift_next     = fmt_shift;
    fmt_index_next     = fmt_index;
    data_total_next    = data_total;
    step_data          = 1'b0;
    step_sum           = 1'b0;
    step_err           = 1'b0;
    sd                 = 1'b0;
    id_w               = '0;
    size_w             = '0;

    if (phase inside {[PH_FORM:PH_DATA_BODY]} && riff_consumed != '1) begin
      riff_consumed_next = riff_consumed + 33'd1;
    end

    case (phase)
      PH_TOP_HDR: begin
        header_shift_next[{header_count[2:0], 3'b000} +: 8] = byte_req.in_byte;
        header_count_next = header_count + 4'd1;
        if (header_count[2:0] == 3'd7) begin
          id_w   = header_shift_next[31:0];
          size_w = header_shift_next[63:32];
          header_count_next = '0;
          header_shift_next = '0;
          if (id_w == ID_RIFF) begin
            riff_size_next     = size_w;
            riff_consumed_next = '0;
            phase_next         = PH_FORM;
          end else begin
            body_left_next = size_w;
            phase_next     = (size_w != '0) ? PH_TOP_SKIP : PH_TOP_HDR;
          end
        end
      end
      PH_TOP_SKIP: begin
        body_left_next = body_left - 32'd1;
        if (body_left_next == '0) phase_next = PH_TOP_HDR;
      end
      PH_FORM: begin
        header_shift_next[{header_count[1:0], 3'b000} +: 8] = byte_req.in_byte;
        header_count_next = header_count + 4'd1;
        if (header_count[1:0] == 2'd3) begin
          id_w = header_shift_next[31:0];
          header_count_next = '0;
          header_shift_next = '0;
          if (id_w == ID_WAVE) begin
            sd = 1'b1;
          end else begin
            body_left_next = (riff_size > 32'd4) ? riff_size - 32'd4 : '0;
            phase_next     = (body_left_next != '0) ? PH_TOP_SKIP : PH_TOP_HDR;
          end
        end
      end
      PH_SUB_HDR: begin
        header_shift_next[{header_count[2:0], 3'b000} +: 8] = byte_req.in_byte;
        header_count_next = header_count + 4'd1;
        if (header_count[2:0] == 3'd7) begin
          id_w   = header_shift_next[31:0];
          size_w = header_shift_next[63:32];
          header_count_next = '0;
          header_shift_next = '0;
          body_left_next    = size_w;
          if (id_w == ID_FMT && !fmt_found) begin
            fmt_found_next = 1'b1;
            fmt_index_next = '0;
            phase_next     = PH_FMT_BODY;
          end else if (id_w == ID_DATA && fmt_found) begin
            data_total_next = data_total + size_w;
            phase_next      = PH_DATA_BODY;
          end else begin
            phase_next = PH_SUB_SKIP;
          end
          if (size_w == '0) sd = 1'b1;
        end
      end
      PH_SUB_SKIP, PH_FMT_BODY, PH_DATA_BODY: begin
        if (phase == PH_FMT_BODY && !fmt_index[4]) begin
          fmt_shift_next[{fmt_index[3:0], 3'b000} +: 8] = byte_req.in_byte;
          fmt_index_next = fmt_index + 5'd1;
        end
        if (phase == PH_DATA_BODY) step_data = 1'b1;
        body_left_next = body_left - 32'd1;
        if (body_left_next == '0) sd = 1'b1;
      end
      default: begin
      end
    endcase

    if (sd) begin
      if (riff_consumed_next >= {1'b0, riff_size}) begin
        if (fmt_found_next) begin
          step_sum   = 1'b1;
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_TOP_HDR;
        end
      end else begin
        phase_next = PH_SUB_HDR;
      end
      header_count_next = '0;
      header_shift_next = '0;
    end

    if (byte_req.end_of_stream && phase_next != PH_DONE) step_err = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      phase         <= PH_TOP_HDR;
      header_shift  <= '0;
      header_count  <= '0;
      body_left     <= '0;
      riff_size     <= '0;
      riff_consumed <= '0;
      fmt_found     <= 1'b0;
      fmt_shift     <= '0;
      fmt_index     <= '0;
      data_total    <= '0;
    end else if (acc) begin
      phase         <= phase_next;
      header_shift  <= header_shift_next;
      header_count  <= header_count_next;
      body_left     <= body_left_next;
      riff_size     <= riff_size_next;
      riff_consumed <= riff_consumed_next;
      fmt_found     <= fmt_found_next;
      fmt_shift     <= fmt_shift_next;
      fmt_index     <= fmt_index_next;
      data_total    <= data_total_next;
    end
  end

  always_comb begin
    ctrl_next = ctrl;
    load_data = 1'b0;
    load_sum  = 1'b0;
    load_err  = 1'b0;
    clr       = 1'b0;
    case (ctrl)
      C_IDLE: begin
        if (acc) ctrl_next = C_EMIT;
      end
      C_EMIT: begin
        if (has_data) begin
          if (out_free) begin
            load_data = 1'b1;
            if (!has_sum && !has_err) begin
              clr       = pend_reset;
              ctrl_next = C_IDLE;
            end
          end
        end else if (has_sum) begin
          ctrl_next = C_MUL;
        end else if (has_err) begin
          if (out_free) begin
            load_err  = 1'b1;
            clr       = pend_reset;
            ctrl_next = C_IDLE;
          end
        end else begin
          clr       = pend_reset;
          ctrl_next = C_IDLE;
        end
      end
      C_MUL: ctrl_next = C_DIV;
      C_DIV: begin
        if (div_count == '0) ctrl_next = C_SUM;
      end
      C_SUM: begin
        if (out_free) begin
          load_sum  = 1'b1;
          ctrl_next = C_EMIT;
        end
      end
      default: ctrl_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= C_IDLE;
    end else begin
      ctrl <= ctrl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_data   <= 1'b0;
      has_sum    <= 1'b0;
      has_err    <= 1'b0;
      pend_reset <= 1'b0;
    end else if (acc) begin
      has_data   <= step_data;
      has_sum    <= step_sum;
      has_err    <= step_err;
      pend_reset <= byte_req.end_of_stream;
    end else begin
      if (load_data) has_data <= 1'b0;
      if (load_sum) has_sum <= 1'b0;
      if (load_err) has_err <= 1'b0;
      if (clr) pend_reset <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) data_hold <= byte_req.in_byte;
  end

  assign rem_sh = {rem[31:0], dvd[DVD_W-1]};
  assign div_ge = (rem_sh >= {1'b0, rate});

  always_ff @(posedge clk) begin
    if (ctrl == C_MUL) begin
      dvd       <= DVD_W'(data_total) * DVD_W'(MS_PER_S);
      rem       <= '0;
      quo       <= '0;
      div_count <= DCNT_W'(DVD_W - 1);
    end else if (ctrl == C_DIV) begin
      rem       <= div_ge ? rem_sh - {1'b0, rate} : rem_sh;
      dvd       <= {dvd[DVD_W-2:0], 1'b0};
      quo       <= {quo[DVD_W-2:0], div_ge};
      div_count <= div_count - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_data || load_sum || load_err) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_comb begin
    result_next = '0;
    if (load_data) begin
      result_next.kind      = KIND_DATA;
      result_next.data_byte = data_hold;
    end else if (load_sum) begin
      result_next.kind              = KIND_SUM;
      result_next.format_tag        = fmt_shift[15:0];
      result_next.channels          = fmt_shift[31:16];
      result_next.sample_freq       = fmt_shift[63:32];
      result_next.avg_bytes_per_sec = rate;
      result_next.block_align       = fmt_shift[111:96];
      result_next.bits_per_sample   = fmt_shift[127:112];
      result_next.wave_bytes        = data_total;
      result_next.play_time_ms      = (quo[DVD_W-1:32] != '0) ? '1 : quo[31:0];
    end else begin
      result_next.kind = KIND_ERR;
    end
  end

  always_ff @(posedge clk) begin
    if (load_data || load_sum || load_err) begin
      result <= result_next;
    end
  end

  a_accept_to_emit: assert property (@(posedge clk) disable iff (rst)
    acc |=> ctrl == C_EMIT)
    else $error("accepted request did not enter emit");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    ctrl == C_IDLE |-> !has_data && !has_sum && !has_err && !pend_reset)
    else $error("idle with pending results");

  a_sum_err_excl: assert property (@(posedge clk) disable iff (rst)
    !(has_sum && has_err))
    else $error("summary and error pending together");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    ctrl == C_DIV && div_count == '0 |=> ctrl == C_SUM)
    else $error("divider did not finish");

endmodule

>>> dv/riff_wave_stream_parser_core_tb.sv
`timescale 1ns / 100ps

module riff_wave_stream_parser_core_tb;
  import rwsp_pkg::*;

  typedef struct {
    in_t req;
    bit  drain;
  } wav_byte_t;

  logic clk;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_stall;
  in_t  byte_req = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_t result;

  wav_byte_t   wav_stream[$];
  logic [7:0]  file_buf[$];
  out_t        parser_outputs[$];
  int unsigned bytes_taken = 0;
  int unsigned bytes_total = 0;
  int unsigned mismatches = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          feed_quiet = 1'b0;
  bit          sink_quiet = 1'b0;

  phase_t      st_phase;
  logic [63:0] hdr_bits;
  int unsigned hdr_cnt;
  logic [31:0] body_rem;
  logic [31:0] riff_len;
  logic [32:0] riff_used;
  bit          fmt_seen;
  logic [7:0]  fmt_bytes[16];
  int unsigned fmt_pos;
  logic [31:0] wave_sum;

  riff_wave_stream_parser_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_req     (byte_req),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] fmt16(int unsigned at);
    return {fmt_bytes[at+1], fmt_bytes[at]};
  endfunction

  function automatic logic [31:0] fmt32(int unsigned at);
    return {fmt16(at + 2), fmt16(at)};
  endfunction

  task automatic clear_parser();
    st_phase  = PH_TOP_HDR;
    hdr_bits  = '0;
    hdr_cnt   = 0;
    body_rem  = '0;
    riff_len  = '0;
    riff_used = '0;
    fmt_seen  = 1'b0;
    foreach (fmt_bytes[k]) fmt_bytes[k] = '0;
    fmt_pos   = 0;
    wave_sum  = '0;
  endtask

  task automatic push_output(logic [1:0] kind, logic [7:0] b);
    out_t        r;
    logic [63:0] quot;
    r = '0;
    r.kind = kind;
    r.data_byte = b;
    if (kind == KIND_SUM) begin
      r.format_tag        = fmt16(0);
      r.channels          = fmt16(2);
      r.sample_freq       = fmt32(4);
      r.avg_bytes_per_sec = fmt32(8);
      r.block_align       = fmt16(12);
      r.bits_per_sample   = fmt16(14);
      r.wave_bytes        = wave_sum;
      r.play_time_ms      = '1;
      if (r.avg_bytes_per_sec != 0) begin
        quot = 64'(wave_sum) * 64'(MS_PER_S) / 64'(r.avg_bytes_per_sec);
        if (quot < 64'hFFFF_FFFF) r.play_time_ms = quot[31:0];
      end
    end
    parser_outputs.push_back(r);
  endtask

  task automatic end_subchunk();
    if (riff_used >= {1'b0, riff_len}) begin
      if (fmt_seen) begin
        push_output(KIND_SUM, 8'h00);
        st_phase = PH_DONE;
      end else begin
        st_phase = PH_TOP_HDR;
      end
    end else begin
      st_phase = PH_SUB_HDR;
    end
    hdr_cnt  = 0;
    hdr_bits = '0;
  endtask

  task automatic parse_wav_byte(in_t req);
    logic [7:0]  b;
    logic [31:0] id;
    logic [31:0] sz;
    b = req.in_byte;
    if (st_phase >= PH_FORM && st_phase <= PH_DATA_BODY && riff_used != '1) riff_used++;
    case (st_phase)
      PH_TOP_HDR: begin
        hdr_bits[8*hdr_cnt +: 8] = b;
        hdr_cnt++;
        if (hdr_cnt == 8) begin
          id = hdr_bits[31:0];
          sz = hdr_bits[63:32];
          hdr_cnt  = 0;
          hdr_bits = '0;
          if (id == ID_RIFF) begin
            riff_len  = sz;
            riff_used = '0;
            st_phase  = PH_FORM;
          end else begin
            body_rem = sz;
            if (sz != 0) st_phase = PH_TOP_SKIP;
            else st_phase = PH_TOP_HDR;
          end
        end
      end
      PH_TOP_SKIP: begin
        body_rem--;
        if (body_rem == 0) st_phase = PH_TOP_HDR;
      end
      PH_FORM: begin
        hdr_bits[8*hdr_cnt +: 8] = b;
        hdr_cnt++;
        if (hdr_cnt == 4) begin
          id = hdr_bits[31:0];
          hdr_cnt  = 0;
          hdr_bits = '0;
          if (id == ID_WAVE) begin
            end_subchunk();
          end else begin
            body_rem = (riff_len > 4) ? riff_len - 4 : 32'd0;
            if (body_rem != 0) st_phase = PH_TOP_SKIP;
            else st_phase = PH_TOP_HDR;
          end
        end
      end
      PH_SUB_HDR: begin
        hdr_bits[8*hdr_cnt +: 8] = b;
        hdr_cnt++;
        if (hdr_cnt == 8) begin
          id = hdr_bits[31:0];
          sz = hdr_bits[63:32];
          hdr_cnt  = 0;
          hdr_bits = '0;
          body_rem = sz;
          if (id == ID_FMT && !fmt_seen) begin
            fmt_seen = 1'b1;
            fmt_pos  = 0;
            st_phase = PH_FMT_BODY;
          end else if (id == ID_DATA && fmt_seen) begin
            wave_sum = wave_sum + sz;
            st_phase = PH_DATA_BODY;
          end else begin
            st_phase = PH_SUB_SKIP;
          end
          if (sz == 0) end_subchunk();
        end
      end
      PH_SUB_SKIP, PH_FMT_BODY, PH_DATA_BODY: begin
        if (st_phase == PH_FMT_BODY && fmt_pos < 16) begin
          fmt_bytes[fmt_pos] = b;
          fmt_pos++;
        end
        if (st_phase == PH_DATA_BODY) push_output(KIND_DATA, b);
        body_rem--;
        if (body_rem == 0) end_subchunk();
      end
      default: ;
    endcase
    if (req.end_of_stream) begin
      if (st_phase != PH_DONE) push_output(KIND_ERR, 8'h00);
      clear_parser();
    end
  endtask

  task automatic note_mismatch(string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic cmp_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", field, got, want));
  endtask

  task automatic check_result(out_t got);
    out_t want;
    if (parser_outputs.size() == 0) begin
      note_mismatch($sformatf("result with none pending, kind %0d", got.kind));
    end else begin
      want = parser_outputs.pop_front();
      cmp_field("kind", got.kind, want.kind);
      cmp_field("data_byte", got.data_byte, want.data_byte);
      cmp_field("format_tag", got.format_tag, want.format_tag);
      cmp_field("channels", got.channels, want.channels);
      cmp_field("sample_freq", got.sample_freq, want.sample_freq);
      cmp_field("avg_bytes_per_sec", got.avg_bytes_per_sec, want.avg_bytes_per_sec);
      cmp_field("block_align", got.block_align, want.block_align);
      cmp_field("bits_per_sample", got.bits_per_sample, want.bits_per_sample);
      cmp_field("wave_bytes", got.wave_bytes, want.wave_bytes);
      cmp_field("play_time_ms", got.play_time_ms, want.play_time_ms);
    end
  endtask

  task automatic add32(logic [31:0] v);
    for (int k = 0; k < 4; k++) file_buf.push_back(v[8*k +: 8]);
  endtask

  task automatic add_noise(int unsigned n);
    repeat (n) file_buf.push_back(8'($urandom));
  endtask

  task automatic add_chunk(logic [31:0] id, int unsigned sz);
    add32(id);
    add32(sz);
    add_noise(sz);
  endtask

  task automatic add_fmt();
    logic [127:0] body;
    int unsigned  sz;
    body = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 3))
      0: body[95:64] = '0;
      1: body[95:64] = $urandom_range(1, 255);
      2: body[95:64] = '1;
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: sz = $urandom_range(0, 15);
      1: sz = $urandom_range(17, 22);
      default: sz = 16;
    endcase
    add32(ID_FMT);
    add32(sz);
    for (int k = 0; k < sz; k++) begin
      if (k < 16) file_buf.push_back(body[8*k +: 8]);
      else file_buf.push_back(8'($urandom));
    end
  endtask

  task automatic add_riff_wave(bit with_fmt);
    int unsigned size_at;
    int unsigned body_at;
    int unsigned exact;
    logic [31:0] claimed;
    add32(ID_RIFF);
    size_at = file_buf.size();
    add32(32'd0);
    add32(ID_WAVE);
    body_at = file_buf.size();
    if (!with_fmt || $urandom_range(0, 3) == 0) add_chunk(ID_DATA, $urandom_range(0, 4));
    if ($urandom_range(0, 3) == 0) add_chunk($urandom, $urandom_range(0, 5));
    if (with_fmt) begin
      add_fmt();
      if ($urandom_range(0, 4) == 0) add_chunk(ID_FMT, $urandom_range(0, 6));
      repeat ($urandom_range(1, 3)) begin
        add_chunk(ID_DATA, $urandom_range(0, 12));
        if ($urandom_range(0, 3) == 0) add_chunk($urandom, $urandom_range(0, 4));
      end
    end
    exact = 4 + file_buf.size() - body_at;
    case ($urandom_range(0, 7))
      0: claimed = $urandom_range(0, exact);
      1: claimed = exact + $urandom_range(1, 8);
      default: claimed = exact;
    endcase
    for (int k = 0; k < 4; k++) file_buf[size_at+k] = claimed[8*k +: 8];
  endtask

  task automatic add_random_file();
    logic [31:0] id;
    int unsigned sz;
    if ($urandom_range(0, 7) == 0) begin
      add_noise($urandom_range(1, 12));
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        id = $urandom;
        if (id == ID_RIFF) id = ~id;
        add_chunk(id, $urandom_range(0, 6));
      end
      if ($urandom_range(0, 5) == 0) begin
        id = $urandom;
        if (id == ID_WAVE) id = ~id;
        sz = $urandom_range(0, 10);
        add32(ID_RIFF);
        add32(sz);
        add32(id);
        add_noise(sz > 4 ? sz - 4 : 0);
      end
      if ($urandom_range(0, 7) == 0) add_riff_wave(1'b0);
      add_riff_wave(1'b1);
      if ($urandom_range(0, 2) == 0) add_noise($urandom_range(1, 4));
      if ($urandom_range(0, 7) == 0) begin
        sz = $urandom_range(1, file_buf.size());
        while (file_buf.size() > sz) void'(file_buf.pop_back());
      end
    end
  endtask

  task automatic send_file(bit drain);
    wav_byte_t it;
    for (int k = 0; k < file_buf.size(); k++) begin
      it.req.in_byte       = file_buf[k];
      it.req.end_of_stream = (k == file_buf.size() - 1);
      it.drain             = drain && (k == 0);
      wav_stream.push_back(it);
    end
    file_buf.delete();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (byte_valid && !byte_stall) begin
        parse_wav_byte(byte_req);
        bytes_taken++;
        if ($urandom_range(0, 39) == 0) feed_quiet = !feed_quiet;
        gap_left = feed_quiet ? 0 : $urandom_range(0, 3);
        if (gap_left > 0) begin
          gap_left--;
          byte_valid <= 1'b0;
        end else if (wav_stream.size() > 0 &&
                     !(wav_stream[0].drain && parser_outputs.size() != 0)) begin
          byte_req   <= wav_stream[0].req;
          byte_valid <= 1'b1;
          wav_stream.delete(0);
        end else begin
          byte_valid <= 1'b0;
        end
      end else if (!byte_valid) begin
        // hold off a drain request until every pending result is out
        if (gap_left > 0) begin
          gap_left--;
        end else if (wav_stream.size() > 0 &&
                     !(wav_stream[0].drain && parser_outputs.size() != 0)) begin
          byte_req   <= wav_stream[0].req;
          byte_valid <= 1'b1;
          wav_stream.delete(0);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        check_result(result);
        if ($urandom_range(0, 39) == 0) sink_quiet = !sink_quiet;
        stall_left = sink_quiet ? 0 : $urandom_range(0, 3);
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    clear_parser();
    file_buf.push_back(8'hFF);
    send_file(1'b0);
    file_buf.push_back(8'h00);
    send_file(1'b0);
    add32(ID_RIFF);
    add32(32'd12);
    add32(ID_WAVE);
    add32(ID_FMT);
    add32(32'd0);
    file_buf.push_back(8'hFF);
    file_buf.push_back(8'hFF);
    send_file(1'b1);
    add_random_file();
    send_file(1'b1);
    while (wav_stream.size() < 1024) begin
      add_random_file();
      send_file($urandom_range(0, 5) == 0);
    end
    bytes_total = wav_stream.size();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (bytes_taken < bytes_total) @(posedge clk);
    while (parser_outputs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> files.f
design/rwsp_pkg.sv
design/riff_wave_stream_parser_core.sv
dv/riff_wave_stream_parser_core_tb.sv
